// ===== design/cpis_pkg.sv =====
package cpis_pkg;

	localparam int MAX_INTERVALS = 16;
	localparam int CODE_W        = 21;
	localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
	localparam int COUNT_W       = 5;

	typedef logic [CODE_W-1:0]        code_t;
	typedef logic [CODE_W:0]          code_ext_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [COUNT_W-1:0]       count_out_t;
	typedef logic [MAX_INTERVALS-1:0] lane_mask_t;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_WRITE,
		ST_COLLAPSE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic eval_emit;
		logic write;
		logic collapse;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic out_free;
		logic multi_merge;
		logic merge_last;
	} status_t;

endpackage

// ===== design/cpis_if.sv =====
interface cpis_req_if;
	logic                valid;
	logic                ready;
	logic                operation;
	cpis_pkg::code_t     first_code;
	cpis_pkg::code_t     last_code;

	modport source (output valid, operation, first_code, last_code, input ready);
	modport sink (input valid, operation, first_code, last_code, output ready);
endinterface

interface cpis_rsp_if;
	logic                   valid;
	logic                   ready;
	logic                   is_member;
	logic                   table_full;
	cpis_pkg::count_out_t   interval_count;

	modport source (output valid, is_member, table_full, interval_count, input ready);
	modport sink (input valid, is_member, table_full, interval_count, output ready);
endinterface

interface cpis_cfg_if;
	logic valid;
	logic ready;
	logic invert_class;

	modport source (output valid, invert_class, input ready);
	modport sink (input valid, invert_class, output ready);
endinterface

// ===== design/cpis_ctrl.sv =====
module cpis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  cpis_pkg::status_t  status,
	output cpis_pkg::cmd_t     cmd
);

	cpis_pkg::state_t state_q;
	cpis_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpis_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cpis_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = cpis_pkg::ST_EVAL;
				end
			end
			cpis_pkg::ST_EVAL: begin
				if (!status.is_query) begin
					state_d = cpis_pkg::ST_WRITE;
				end else if (status.out_free) begin
					state_d = cpis_pkg::ST_IDLE;
				end else begin
					state_d = cpis_pkg::ST_FINISH;
				end
			end
			cpis_pkg::ST_WRITE: begin
				if (status.multi_merge) begin
					state_d = cpis_pkg::ST_COLLAPSE;
				end else begin
					state_d = cpis_pkg::ST_FINISH;
				end
			end
			cpis_pkg::ST_COLLAPSE: begin
				if (status.merge_last) begin
					state_d = cpis_pkg::ST_FINISH;
				end
			end
			cpis_pkg::ST_FINISH: begin
				if (status.out_free) begin
					state_d = cpis_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cpis_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			cpis_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				cmd.accept = item_valid;
			end
			cpis_pkg::ST_EVAL: begin
				cmd.eval      = 1'b1;
				cmd.eval_emit = status.is_query & status.out_free;
			end
			cpis_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
			end
			cpis_pkg::ST_COLLAPSE: begin
				cmd.collapse = 1'b1;
			end
			cpis_pkg::ST_FINISH: begin
				cmd.emit = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== design/cpis_datapath.sv =====
module cpis_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               operation,
	input  cpis_pkg::code_t    first_code,
	input  cpis_pkg::code_t    last_code,
	input  logic               invert,
	input  cpis_pkg::cmd_t     cmd,
	output cpis_pkg::status_t  status,
	cpis_rsp_if.source         result
);

	localparam int N = cpis_pkg::MAX_INTERVALS;

	cpis_pkg::code_t      low_q  [N];
	cpis_pkg::code_t      high_q [N];
	cpis_pkg::code_t      low_dn [N];
	cpis_pkg::code_t      high_dn[N];
	cpis_pkg::code_t      low_up [N];
	cpis_pkg::code_t      high_up[N];
	cpis_pkg::count_t     count_q;

	cpis_pkg::op_t        op_q;
	cpis_pkg::code_t      lo_q;
	cpis_pkg::code_t      hi_q;

	cpis_pkg::lane_mask_t below_q;
	cpis_pkg::lane_mask_t abs_q;
	cpis_pkg::lane_mask_t merge_q;
	logic                 res_member_q;
	logic                 res_full_q;
	logic                 out_valid_q;

	cpis_pkg::lane_mask_t below_d;
	cpis_pkg::lane_mask_t abs_d;
	cpis_pkg::lane_mask_t hit_d;
	logic                 member_now;

	cpis_pkg::lane_mask_t first_abs;
	cpis_pkg::lane_mask_t last_abs;
	cpis_pkg::lane_mask_t ins_mask;
	cpis_pkg::lane_mask_t up_mask;
	cpis_pkg::lane_mask_t shift_mask;
	cpis_pkg::code_t      sel_low;
	cpis_pkg::code_t      sel_high;
	cpis_pkg::code_t      new_lo;
	cpis_pkg::code_t      new_hi;
	logic                 any_abs;
	logic                 full;
	logic                 out_free;

	// per-lane classification against the pending item
	always_comb begin
		for (int j = 0; j < N; j++) begin
			logic lane_valid;
			logic lane_above;
			lane_valid = cpis_pkg::count_t'(j) < count_q;
			below_d[j] = lane_valid & ((cpis_pkg::code_ext_t'(high_q[j]) +
				cpis_pkg::code_ext_t'(1)) < cpis_pkg::code_ext_t'(lo_q));
			lane_above = cpis_pkg::code_ext_t'(low_q[j]) >
				(cpis_pkg::code_ext_t'(hi_q) + cpis_pkg::code_ext_t'(1));
			abs_d[j]   = lane_valid & ~below_d[j] & ~lane_above;
			hit_d[j]   = lane_valid & (low_q[j] <= lo_q) & (lo_q <= high_q[j]);
		end
		member_now = (|hit_d) ^ invert;
	end

	// neighbor taps for shifting the table by one lane
	always_comb begin
		low_dn[0]    = low_q[0];
		high_dn[0]   = high_q[0];
		low_up[N-1]  = low_q[N-1];
		high_up[N-1] = high_q[N-1];
		for (int j = 1; j < N; j++) begin
			low_dn[j]    = low_q[j-1];
			high_dn[j]   = high_q[j-1];
			low_up[j-1]  = low_q[j];
			high_up[j-1] = high_q[j];
		end
	end

	always_comb begin
		first_abs = abs_q & ~{abs_q[N-2:0], 1'b0};
		last_abs  = abs_q & ~{1'b0, abs_q[N-1:1]};
		ins_mask  = ~below_q & {below_q[N-2:0], 1'b1};
		up_mask   = ~below_q & ~ins_mask;
		any_abs   = |abs_q;
		full      = ~any_abs & (count_q == cpis_pkg::count_t'(N));
		sel_low   = '0;
		sel_high  = '0;
		for (int j = 0; j < N; j++) begin
			sel_low  = sel_low | (low_q[j] & {cpis_pkg::CODE_W{first_abs[j]}});
			sel_high = sel_high | (high_q[j] & {cpis_pkg::CODE_W{last_abs[j]}});
		end
		new_lo = (any_abs && sel_low < lo_q) ? sel_low : lo_q;
		new_hi = (any_abs && sel_high > hi_q) ? sel_high : hi_q;
	end

	// lanes at and above the next extra absorbed entry move down
	always_comb begin
		logic run;
		run = 1'b0;
		for (int j = 0; j < N; j++) begin
			run           = run | merge_q[j];
			shift_mask[j] = run;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && !full) begin
			for (int j = 0; j < N; j++) begin
				if (any_abs) begin
					if (first_abs[j]) begin
						low_q[j]  <= new_lo;
						high_q[j] <= new_hi;
					end
				end else if (ins_mask[j]) begin
					low_q[j]  <= new_lo;
					high_q[j] <= new_hi;
				end else if (up_mask[j]) begin
					low_q[j]  <= low_dn[j];
					high_q[j] <= high_dn[j];
				end
			end
		end else if (cmd.collapse) begin
			for (int j = 0; j < N; j++) begin
				if (shift_mask[j]) begin
					low_q[j]  <= low_up[j];
					high_q[j] <= high_up[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.write && !full && !any_abs) begin
			count_q <= count_q + cpis_pkg::count_t'(1);
		end else if (cmd.collapse) begin
			count_q <= count_q - cpis_pkg::count_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= cpis_pkg::op_t'(operation);
			if (operation == cpis_pkg::OP_ADD && first_code > last_code) begin
				lo_q <= last_code;
				hi_q <= first_code;
			end else begin
				lo_q <= first_code;
				hi_q <= last_code;
			end
		end
		if (cmd.eval) begin
			below_q      <= below_d;
			abs_q        <= abs_d;
			res_member_q <= (op_q == cpis_pkg::OP_QUERY) ? member_now : 1'b0;
			res_full_q   <= 1'b0;
		end
		if (cmd.write) begin
			res_full_q <= full;
			merge_q    <= abs_q & ~first_abs;
		end else if (cmd.collapse) begin
			merge_q <= merge_q & {1'b0, merge_q[N-1:1]};
		end
	end

	// result register
	assign out_free = ~out_valid_q | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.eval_emit || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_emit || cmd.emit) begin
			result.is_member      <= cmd.eval_emit ? member_now : res_member_q;
			result.table_full     <= cmd.eval_emit ? 1'b0 : res_full_q;
			result.interval_count <= cpis_pkg::count_out_t'(count_q);
		end
	end

	assign result.valid = out_valid_q;

	assign status.is_query    = (op_q == cpis_pkg::OP_QUERY);
	assign status.out_free    = out_free;
	assign status.multi_merge = |(abs_q & {1'b0, abs_q[N-1:1]});
	assign status.merge_last  = ~|(merge_q & {1'b0, merge_q[N-1:1]});

endmodule

// ===== design/code_point_interval_set_top.sv =====
// Code-point interval set: a sorted table of disjoint, non-touching ranges.
// Channels: item (operation, first_code, last_code) in, result (is_member,
// table_full, interval_count) out, cfg writes invert_class. All use
// valid/ready; a beat moves when both are high. cfg is always ready.
// A query beat reads all table lanes at once: the result is registered
// in the evaluate state after the item beat, or in the finish state once
// the result register frees. An add beat classifies lanes, then writes
// the merged or inserted range in the write state and takes one collapse
// step for each extra interval that the add absorbs, since the table
// closes the gap one lane per cycle, before it finishes. The next item
// is taken in the idle state after the result is loaded.
// The result register holds a beat while the receiver stalls; the block
// takes one further item meanwhile and waits with its result until the
// register frees.
// Reset empties the table, clears invert_class and drops any pending beat.
module code_point_interval_set_top (
	input  logic        clk,
	input  logic        arst_n,
	cpis_cfg_if.sink    cfg,
	cpis_req_if.sink    item,
	cpis_rsp_if.source  result
);

	logic               invert_q;
	cpis_pkg::cmd_t     cmd;
	cpis_pkg::status_t  status;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q <= 1'b0;
		end else if (cfg.valid) begin
			invert_q <= cfg.invert_class;
		end
	end

	cpis_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	cpis_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.operation  (item.operation),
		.first_code (item.first_code),
		.last_code  (item.last_code),
		.invert     (invert_q),
		.cmd        (cmd),
		.status     (status),
		.result     (result)
	);

endmodule
